>>> sv/illegal_opcode_trap_bus_sequencer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the trap bus sequencer
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ILLEGAL_OPCODE_TRAP_BUS_SEQUENCER_ASSERT_SVH
`define ILLEGAL_OPCODE_TRAP_BUS_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every edge outside reset.
`define IOTBS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("iotbs assertion failed");

// Checked at every edge, also during reset.
`define IOTBS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("iotbs assertion failed");

`else

`define IOTBS_ASSERT(name, clk, rst_n, prop)
`define IOTBS_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

>>> sv/iotbs_pkg.sv
// ---------------------------------------------------------------------------
// Trap bus sequencer package
// Item layouts, operation and status codes, step codes and bus constants.
// ---------------------------------------------------------------------------
package iotbs_pkg;

    typedef enum logic [1:0] {
        KIND_CLEAR    = 2'd0,
        KIND_BEGIN_IO = 2'd1,
        KIND_BEGIN_UI = 2'd2,
        KIND_ACCEPT   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_RAM_RD  = 2'd0,
        OP_RAM_WR  = 2'd1,
        OP_PORT_RD = 2'd2,
        OP_PORT_WR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_INVALID  = 2'd1,
        ST_FAILED   = 2'd2,
        ST_COMPLETE = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'd0,
        S_IP_LO  = 5'd1,
        S_IP_HI  = 5'd2,
        S_CS_LO  = 5'd3,
        S_CS_HI  = 5'd4,
        S_WCS_LO = 5'd5,
        S_WCS_HI = 5'd6,
        S_WIP_LO = 5'd7,
        S_WIP_HI = 5'd8,
        S_M_OCW3 = 5'd9,
        S_M_ISR  = 5'd10,
        S_M_IMR  = 5'd11,
        S_S_OCW3 = 5'd12,
        S_S_ISR  = 5'd13,
        S_S_IMR  = 5'd14,
        S_WS_IMR = 5'd15,
        S_S_EOI  = 5'd16,
        S_WM_IMR = 5'd17,
        S_M_EOI  = 5'd18,
        S_CAUSE  = 5'd19,
        S_DONE   = 5'd20
    } step_t;

    // Configuration register indexes.
    localparam logic REG_CAUSE_ADDR = 1'b0;

    localparam logic [31:0] CAUSE_ADDR_RESET = 32'd1131;
    localparam logic [31:0] PIC1_CMD         = 32'h20;
    localparam logic [31:0] PIC1_DATA        = 32'h21;
    localparam logic [31:0] PIC2_CMD         = 32'ha0;
    localparam logic [31:0] PIC2_DATA        = 32'ha1;
    localparam logic [7:0]  OCW3_READ_ISR    = 8'h0b;
    localparam logic [7:0]  PIC_EOI          = 8'h20;
    localparam logic [7:0]  CASCADE_KEEP     = 8'hfb;
    localparam logic [7:0]  NO_CAUSE         = 8'hff;
    localparam logic [15:0] POINTER_WRAP     = 16'hffff;
    localparam logic [32:0] STACK_LIMIT      = 33'h0_ffff_fffc;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] stack_segment;
        logic [31:0] stack_offset;
        logic [1:0]  echo_kind;
        logic [31:0] echo_address;
        logic [7:0]  echo_value;
        logic [7:0]  read_data;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  run_status;
        logic        next_valid;
        logic [1:0]  next_kind;
        logic [31:0] next_address;
        logic [7:0]  next_value;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [31:0] address;
        logic [7:0]  value;
    } req_t;

    typedef struct packed {
        step_t       step;
        status_t     status;
        logic [31:0] stack_address;
        logic [15:0] saved_pointer;
        logic [15:0] saved_segment;
        logic [7:0]  pri_isr;
        logic [7:0]  pri_imr;
        logic [7:0]  sec_isr;
        logic [7:0]  sec_imr;
    } state_t;

endpackage

>>> sv/iotbs_if.sv
// ---------------------------------------------------------------------------
// Trap bus sequencer channels
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface iotbs_in_if;
    logic                valid;
    logic                ready;
    iotbs_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface iotbs_out_if;
    logic                 valid;
    logic                 ready;
    iotbs_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> sv/iotbs_cfg.sv
// ---------------------------------------------------------------------------
// Trap bus sequencer configuration
// APB register file holding the cause byte address.
// ---------------------------------------------------------------------------
module iotbs_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] cause_address
);

    logic [31:0] cause_addr_reg;
    logic        hit;

    // Word index sits in paddr[2]; the low bits are ignored.
    assign hit    = (paddr[2] == iotbs_pkg::REG_CAUSE_ADDR);
    assign pready = 1'b1;
    assign prdata = hit ? cause_addr_reg : 32'd0;
    assign cause_address = cause_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cause_addr_reg <= iotbs_pkg::CAUSE_ADDR_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            cause_addr_reg <= pwdata;
        end
    end

endmodule

>>> sv/iotbs_core.sv
// ---------------------------------------------------------------------------
// Trap bus sequencer core
// Input register, step logic and result register with the sequencer state.
// ---------------------------------------------------------------------------
`include "illegal_opcode_trap_bus_sequencer_assert.svh"

module iotbs_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       cause_address,
    iotbs_in_if.sink          in_ch,
    iotbs_out_if.source       out_ch
);

    logic                 in_valid_reg;
    iotbs_pkg::in_item_t  in_item_reg;
    logic                 out_valid_reg;
    iotbs_pkg::out_item_t out_item_reg;
    iotbs_pkg::out_item_t out_item_next;
    iotbs_pkg::state_t    state_reg;
    iotbs_pkg::state_t    state_next;

    logic                 advance;
    logic                 fire;
    iotbs_pkg::req_t      cur_req;
    iotbs_pkg::req_t      new_req;
    logic                 echo_is_write;
    logic                 echo_match;
    logic                 ok;
    logic [32:0]          stack_sum;

    // Operation requested in a given state.
    function automatic iotbs_pkg::req_t req_of(iotbs_pkg::state_t s, logic [31:0] cause);
        iotbs_pkg::req_t r;
        logic [15:0]     cs1;
        logic [15:0]     ip1;
        r   = '0;
        cs1 = s.saved_segment + 16'd1;
        ip1 = s.saved_pointer + 16'd1;
        if (s.status == iotbs_pkg::ST_PENDING)
        begin
            r.valid = 1'b1;
            unique case (s.step)
                iotbs_pkg::S_IP_LO:
                begin
                    r.kind = iotbs_pkg::OP_RAM_RD; r.address = s.stack_address;
                end
                iotbs_pkg::S_IP_HI:
                begin
                    r.kind = iotbs_pkg::OP_RAM_RD; r.address = s.stack_address + 32'd1;
                end
                iotbs_pkg::S_CS_LO:
                begin
                    r.kind = iotbs_pkg::OP_RAM_RD; r.address = s.stack_address + 32'd2;
                end
                iotbs_pkg::S_CS_HI:
                begin
                    r.kind = iotbs_pkg::OP_RAM_RD; r.address = s.stack_address + 32'd3;
                end
                iotbs_pkg::S_WCS_LO:
                begin
                    r.kind = iotbs_pkg::OP_RAM_WR; r.address = s.stack_address + 32'd2;
                    r.value = cs1[7:0];
                end
                iotbs_pkg::S_WCS_HI:
                begin
                    r.kind = iotbs_pkg::OP_RAM_WR; r.address = s.stack_address + 32'd3;
                    r.value = cs1[15:8];
                end
                iotbs_pkg::S_WIP_LO:
                begin
                    r.kind = iotbs_pkg::OP_RAM_WR; r.address = s.stack_address;
                    r.value = ip1[7:0];
                end
                iotbs_pkg::S_WIP_HI:
                begin
                    r.kind = iotbs_pkg::OP_RAM_WR; r.address = s.stack_address + 32'd1;
                    r.value = ip1[15:8];
                end
                iotbs_pkg::S_M_OCW3:
                begin
                    r.kind = iotbs_pkg::OP_PORT_WR; r.address = iotbs_pkg::PIC1_CMD;
                    r.value = iotbs_pkg::OCW3_READ_ISR;
                end
                iotbs_pkg::S_M_ISR:
                begin
                    r.kind = iotbs_pkg::OP_PORT_RD; r.address = iotbs_pkg::PIC1_CMD;
                end
                iotbs_pkg::S_M_IMR:
                begin
                    r.kind = iotbs_pkg::OP_PORT_RD; r.address = iotbs_pkg::PIC1_DATA;
                end
                iotbs_pkg::S_S_OCW3:
                begin
                    r.kind = iotbs_pkg::OP_PORT_WR; r.address = iotbs_pkg::PIC2_CMD;
                    r.value = iotbs_pkg::OCW3_READ_ISR;
                end
                iotbs_pkg::S_S_ISR:
                begin
                    r.kind = iotbs_pkg::OP_PORT_RD; r.address = iotbs_pkg::PIC2_CMD;
                end
                iotbs_pkg::S_S_IMR:
                begin
                    r.kind = iotbs_pkg::OP_PORT_RD; r.address = iotbs_pkg::PIC2_DATA;
                end
                iotbs_pkg::S_WS_IMR:
                begin
                    r.kind = iotbs_pkg::OP_PORT_WR; r.address = iotbs_pkg::PIC2_DATA;
                    r.value = s.sec_imr | s.sec_isr;
                end
                iotbs_pkg::S_S_EOI:
                begin
                    r.kind = iotbs_pkg::OP_PORT_WR; r.address = iotbs_pkg::PIC2_CMD;
                    r.value = iotbs_pkg::PIC_EOI;
                end
                iotbs_pkg::S_WM_IMR:
                begin
                    // The cascade line stays unmasked.
                    r.kind = iotbs_pkg::OP_PORT_WR; r.address = iotbs_pkg::PIC1_DATA;
                    r.value = (s.pri_imr | s.pri_isr) & iotbs_pkg::CASCADE_KEEP;
                end
                iotbs_pkg::S_M_EOI:
                begin
                    r.kind = iotbs_pkg::OP_PORT_WR; r.address = iotbs_pkg::PIC1_CMD;
                    r.value = iotbs_pkg::PIC_EOI;
                end
                iotbs_pkg::S_CAUSE:
                begin
                    r.kind = iotbs_pkg::OP_RAM_WR; r.address = cause;
                    r.value = (s.pri_isr == 8'd0) ? iotbs_pkg::NO_CAUSE : s.pri_isr;
                end
                default:
                begin
                    r = '0;
                end
            endcase
        end
        return r;
    endfunction

    assign advance     = !out_valid_reg || out_ch.ready;
    assign fire        = in_valid_reg && advance;
    assign in_ch.ready = !in_valid_reg || advance;

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    assign cur_req = req_of(state_reg, cause_address);

    assign echo_is_write = (in_item_reg.echo_kind == iotbs_pkg::OP_RAM_WR) ||
                           (in_item_reg.echo_kind == iotbs_pkg::OP_PORT_WR);
    assign echo_match = cur_req.valid &&
                        (in_item_reg.echo_kind == cur_req.kind) &&
                        (in_item_reg.echo_address == cur_req.address) &&
                        (!echo_is_write || (in_item_reg.echo_value == cur_req.value));

    assign stack_sum = {13'd0, in_item_reg.stack_segment, 4'd0} +
                       {1'b0, in_item_reg.stack_offset};

    always_comb
    begin
        state_next = state_reg;
        ok         = 1'b0;
        unique case (in_item_reg.kind)
            iotbs_pkg::KIND_CLEAR:
            begin
                state_next = '0;
            end
            iotbs_pkg::KIND_BEGIN_IO,
            iotbs_pkg::KIND_BEGIN_UI:
            begin
                if ((state_reg.status == iotbs_pkg::ST_PENDING) &&
                    (state_reg.step == iotbs_pkg::S_IDLE))
                begin
                    if (in_item_reg.kind == iotbs_pkg::KIND_BEGIN_UI)
                    begin
                        state_next.step = iotbs_pkg::S_M_OCW3;
                        ok = 1'b1;
                    end
                    else if (stack_sum > iotbs_pkg::STACK_LIMIT)
                    begin
                        state_next.status = iotbs_pkg::ST_INVALID;
                    end
                    else
                    begin
                        state_next.stack_address = stack_sum[31:0];
                        state_next.step = iotbs_pkg::S_IP_LO;
                        ok = 1'b1;
                    end
                end
            end
            default:
            begin
                if (!echo_match)
                begin
                    state_next.status = iotbs_pkg::ST_FAILED;
                end
                else
                begin
                    ok = 1'b1;
                    unique case (state_reg.step)
                        iotbs_pkg::S_IP_LO:
                        begin
                            state_next.saved_pointer = {8'd0, in_item_reg.read_data};
                            state_next.step = iotbs_pkg::S_IP_HI;
                        end
                        iotbs_pkg::S_IP_HI:
                        begin
                            state_next.saved_pointer =
                                {in_item_reg.read_data, state_reg.saved_pointer[7:0]};
                            state_next.step = iotbs_pkg::S_CS_LO;
                        end
                        iotbs_pkg::S_CS_LO:
                        begin
                            state_next.saved_segment = {8'd0, in_item_reg.read_data};
                            state_next.step = iotbs_pkg::S_CS_HI;
                        end
                        iotbs_pkg::S_CS_HI:
                        begin
                            // A wrapping IP carries into CS, which is written first.
                            state_next.saved_segment =
                                {in_item_reg.read_data, state_reg.saved_segment[7:0]};
                            state_next.step =
                                (state_reg.saved_pointer == iotbs_pkg::POINTER_WRAP) ?
                                iotbs_pkg::S_WCS_LO : iotbs_pkg::S_WIP_LO;
                        end
                        iotbs_pkg::S_M_ISR:
                        begin
                            state_next.pri_isr = in_item_reg.read_data;
                            state_next.step = (in_item_reg.read_data == 8'd0) ?
                                              iotbs_pkg::S_CAUSE : iotbs_pkg::S_M_IMR;
                        end
                        iotbs_pkg::S_M_IMR:
                        begin
                            state_next.pri_imr = in_item_reg.read_data;
                            state_next.step = iotbs_pkg::S_S_OCW3;
                        end
                        iotbs_pkg::S_S_ISR:
                        begin
                            state_next.sec_isr = in_item_reg.read_data;
                            state_next.step = (in_item_reg.read_data == 8'd0) ?
                                              iotbs_pkg::S_WM_IMR : iotbs_pkg::S_S_IMR;
                        end
                        iotbs_pkg::S_S_IMR:
                        begin
                            state_next.sec_imr = in_item_reg.read_data;
                            state_next.step = iotbs_pkg::S_WS_IMR;
                        end
                        iotbs_pkg::S_CAUSE:
                        begin
                            state_next.step = iotbs_pkg::S_DONE;
                            state_next.status = iotbs_pkg::ST_COMPLETE;
                        end
                        default:
                        begin
                            state_next.step = iotbs_pkg::step_t'(state_reg.step + 5'd1);
                        end
                    endcase
                end
            end
        endcase
    end

    assign new_req = req_of(state_next, cause_address);

    always_comb
    begin
        out_item_next.accepted     = ok;
        out_item_next.run_status   = state_next.status;
        out_item_next.next_valid   = new_req.valid;
        out_item_next.next_kind    = new_req.kind;
        out_item_next.next_address = new_req.address;
        out_item_next.next_value   = new_req.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg <= in_ch.payload;
        end
        if (fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    `IOTBS_ASSERT(a_complete_at_done, clk, rst_n, (state_reg.status == iotbs_pkg::ST_COMPLETE) |-> (state_reg.step == iotbs_pkg::S_DONE))
    `IOTBS_ASSERT(a_no_request_unless_pending, clk, rst_n, (out_valid_reg && (out_item_reg.run_status != iotbs_pkg::ST_PENDING)) |-> !out_item_reg.next_valid)
    `IOTBS_ASSERT(a_clear_resets_state, clk, rst_n, (fire && (in_item_reg.kind == iotbs_pkg::KIND_CLEAR)) |=> ((state_reg.step == iotbs_pkg::S_IDLE) && (state_reg.status == iotbs_pkg::ST_PENDING)))
    `IOTBS_ASSERT(a_accept_status, clk, rst_n, (out_valid_reg && out_item_reg.accepted) |-> ((out_item_reg.run_status == iotbs_pkg::ST_PENDING) || (out_item_reg.run_status == iotbs_pkg::ST_COMPLETE)))
    `IOTBS_ASSERT(a_step_in_range, clk, rst_n, (state_reg.step <= iotbs_pkg::S_DONE))

endmodule

>>> sv/illegal_opcode_trap_bus_sequencer.sv
// ---------------------------------------------------------------------------
// Illegal-opcode trap bus sequencer
// Steps through the bus operations of an illegal-opcode or unexpected
// interrupt trap, checking each echoed operation.
// ---------------------------------------------------------------------------
// The block takes one item per clock cycle, back to back, while the output
// side is not stalled, and gives exactly one result item for each. An item
// passes an input register, the step logic and a result register, which it
// enters when the result register is empty or its item is being taken; a
// stalled result is held while one further item waits in the input register.
// The sequencer state updates as each item enters the result register, which
// keeps the one-cycle rate. The user must write the cause byte address over
// the APB port only while the block is idle; the block does not enforce it.
module illegal_opcode_trap_bus_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    iotbs_in_if.sink    in_ch,
    iotbs_out_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] cause_address;

    iotbs_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .cause_address (cause_address)
    );

    iotbs_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cause_address (cause_address),
        .in_ch         (in_ch),
        .out_ch        (out_ch)
    );

endmodule
